// ===== design/asd_pkg.sv =====
package asd_pkg;

    // Spikes inside the window that make up one shake
    localparam int SPIKES_NEEDED = 4;

    // Spike count holds 0..SPIKES_NEEDED, stamp index addresses 0..SPIKES_NEEDED-1
    localparam int CNT_W = $clog2(SPIKES_NEEDED + 1);
    localparam int IDX_W = (SPIKES_NEEDED > 1) ? $clog2(SPIKES_NEEDED) : 1;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int ACCEL_W = 16;
    localparam int REG_W   = 16;
    localparam int HELD_W  = 3;
    localparam int SQ_W    = 2 * ACCEL_W;
    localparam int ACC_W   = SQ_W + 2;

    // Stream word widths
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS     = 2'd2;

    // Register reset values
    localparam logic [REG_W-1:0] THRESHOLD_RST = 16'd4915;
    localparam logic [REG_W-1:0] WINDOW_RST    = 16'd1000;
    localparam logic [REG_W-1:0] COOLDOWN_RST  = 16'd5000;

    // Input word kinds
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_MASK   = 1'b1;

    // Operand request for the shared squaring unit
    typedef struct packed {
        logic                      diff_mode;
        logic signed [ACCEL_W-1:0] op_a;
        logic signed [ACCEL_W-1:0] op_b;
    } sq_op_t;

endpackage

// ===== design/asd_sq_unit.sv =====
module asd_sq_unit
    import asd_pkg::*;
(
    input  sq_op_t          sq_op,
    output logic [SQ_W-1:0] sq_out
);

    logic signed [ACCEL_W:0] diff;
    logic [ACCEL_W-1:0]      mag;

    // Magnitude is |a - b| in diff mode, otherwise a taken as unsigned
    always_comb begin
        diff = (ACCEL_W + 1)'(sq_op.op_a) - (ACCEL_W + 1)'(sq_op.op_b);
        if (sq_op.diff_mode) begin
            if (diff < 0) begin
                mag = ACCEL_W'(-diff);
            end else begin
                mag = ACCEL_W'(diff);
            end
        end else begin
            mag = ACCEL_W'(sq_op.op_a);
        end
    end

    // One 16x16 unsigned multiplier
    assign sq_out = SQ_W'(mag) * SQ_W'(mag);

endmodule

// ===== design/accel_shake_detector.sv =====
// Shake detector for a 3-axis accelerometer. Each input word is either a
// timestamped sample (tuser = 0) or a mask request (tuser = 1), and each
// yields exactly one result word. A sample that runs the full spike test
// goes through the decode, squaring, ageing, finish and output states
// before the next word is taken: the sequencer feeds the three axis
// differences and the threshold through one shared squaring multiplier,
// then ages the stored stamps one per cycle. Mask requests, masked,
// invalid and first samples go from decode straight to output. s_tready
// is low while an item is being worked on; a finished result sits in the
// output register and the next word is taken while it waits. Configuration
// writes are always taken (cfg_ready is tied high); write them only while idle.
module accel_shake_detector
    import asd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, low bit up: now_ms[31:0], sample_valid[32], accel_x[48:33],
    // accel_y[64:49], accel_z[80:65], mask_length_ms[112:81], zero[119:113]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: cmd[0]
    input  logic [0:0]            s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, low bit up: shake[0], spikes_held[3:1], masked[4], zero[7:5]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_SQ,
        S_AGE,
        S_FIN,
        S_OUT
    } state_t;

    // Squaring steps
    localparam logic [2:0] SQ_X    = 3'd0;
    localparam logic [2:0] SQ_Y    = 3'd1;
    localparam logic [2:0] SQ_Z    = 3'd2;
    localparam logic [2:0] SQ_THR  = 3'd3;
    localparam logic [2:0] SQ_LAST = 3'd4;

    state_t state_reg, state_next;

    // Latched input word
    logic                      cmd_reg, cmd_next;
    logic [TIME_W-1:0]         now_reg, now_next;
    logic                      valid_reg, valid_next;
    logic signed [ACCEL_W-1:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [TIME_W-1:0]         mlen_reg, mlen_next;

    // Detector state
    logic signed [ACCEL_W-1:0] prev_x_reg, prev_x_next;
    logic signed [ACCEL_W-1:0] prev_y_reg, prev_y_next;
    logic signed [ACCEL_W-1:0] prev_z_reg, prev_z_next;
    logic                      first_reg, first_next;
    logic [CNT_W-1:0]          total_reg, total_next;
    logic [TIME_W-1:0]         deadline_reg, deadline_next;

    // Configuration
    logic [REG_W-1:0] thr_reg, thr_next, win_reg, win_next, cool_reg, cool_next;

    // Sequencer datapath
    logic [2:0]       idx_reg, idx_next;
    logic [SQ_W-1:0]  prod_reg, prod_next;
    logic [2:0]       prod_tag_reg, prod_tag_next;
    logic             prod_live_reg, prod_live_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [SQ_W-1:0]  thr2_reg, thr2_next;
    logic [CNT_W-1:0] scan_reg, scan_next, kept_reg, kept_next;

    // Pending result and output register
    logic                  res_shake_reg, res_shake_next;
    logic [CNT_W-1:0]      res_held_reg, res_held_next;
    logic                  res_masked_reg, res_masked_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Spike stamp store
    logic [TIME_W-1:0] stamps_mem [SPIKES_NEEDED];
    logic              st_we;
    logic [IDX_W-1:0]  st_waddr;
    logic [TIME_W-1:0] st_wdata;

    sq_op_t          sq_op;
    logic [SQ_W-1:0] sq_out;
    logic [TIME_W-1:0] age;
    logic [CNT_W-1:0]  cnt_after;
    logic              crossing;

    asd_sq_unit u_sq (
        .sq_op  (sq_op),
        .sq_out (sq_out)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Operand select for the shared squaring unit
    always_comb begin
        sq_op = '0;
        case (idx_reg)
            SQ_X: begin
                sq_op.diff_mode = 1'b1;
                sq_op.op_a      = ax_reg;
                sq_op.op_b      = prev_x_reg;
            end
            SQ_Y: begin
                sq_op.diff_mode = 1'b1;
                sq_op.op_a      = ay_reg;
                sq_op.op_b      = prev_y_reg;
            end
            SQ_Z: begin
                sq_op.diff_mode = 1'b1;
                sq_op.op_a      = az_reg;
                sq_op.op_b      = prev_z_reg;
            end
            SQ_THR: begin
                sq_op.op_a = $signed(thr_reg);
            end
            default: begin
                sq_op = '0;
            end
        endcase
    end

    assign age      = now_reg - stamps_mem[scan_reg[IDX_W-1:0]];
    assign crossing = (acc_reg > ACC_W'(thr2_reg));

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        az_next         = az_reg;
        mlen_next       = mlen_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_z_next     = prev_z_reg;
        first_next      = first_reg;
        total_next      = total_reg;
        deadline_next   = deadline_reg;
        thr_next        = thr_reg;
        win_next        = win_reg;
        cool_next       = cool_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        prod_tag_next   = prod_tag_reg;
        prod_live_next  = prod_live_reg;
        acc_next        = acc_reg;
        thr2_next       = thr2_reg;
        scan_next       = scan_reg;
        kept_next       = kept_reg;
        res_shake_next  = res_shake_reg;
        res_held_next   = res_held_reg;
        res_masked_next = res_masked_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;
        m_tdata_next    = m_tdata_reg;
        st_we           = 1'b0;
        st_waddr        = kept_reg[IDX_W-1:0];
        st_wdata        = stamps_mem[scan_reg[IDX_W-1:0]];
        cnt_after       = kept_reg;

        // Register writes
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SPIKE_THRESHOLD: thr_next  = cfg_data;
                CFG_WINDOW_MS:       win_next  = cfg_data;
                CFG_COOLDOWN_MS:     cool_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser[0];
                    now_next   = s_tdata[31:0];
                    valid_next = s_tdata[32];
                    ax_next    = $signed(s_tdata[48:33]);
                    ay_next    = $signed(s_tdata[64:49]);
                    az_next    = $signed(s_tdata[80:65]);
                    mlen_next  = s_tdata[112:81];
                    state_next = S_DEC;
                end
            end
            // Sort out the words that need no spike test
            S_DEC: begin
                res_shake_next  = 1'b0;
                res_held_next   = total_reg;
                res_masked_next = 1'b0;
                acc_next        = '0;
                idx_next        = SQ_X;
                prod_live_next  = 1'b0;
                state_next      = S_OUT;
                if (cmd_reg == CMD_MASK) begin
                    deadline_next = now_reg + mlen_reg;
                end else if (now_reg < deadline_reg) begin
                    total_next      = '0;
                    first_next      = 1'b1;
                    res_held_next   = '0;
                    res_masked_next = 1'b1;
                end else if (!valid_reg) begin
                    state_next = S_OUT;
                end else if (first_reg) begin
                    prev_x_next = ax_reg;
                    prev_y_next = ay_reg;
                    prev_z_next = az_reg;
                    first_next  = 1'b0;
                end else begin
                    state_next = S_SQ;
                end
            end
            // One square per cycle, folded in the cycle after
            S_SQ: begin
                prod_next      = sq_out;
                prod_tag_next  = idx_reg;
                prod_live_next = (idx_reg != SQ_LAST);
                if (prod_live_reg) begin
                    if (prod_tag_reg == SQ_THR) begin
                        thr2_next = prod_reg;
                    end else begin
                        acc_next = acc_reg + ACC_W'(prod_reg);
                    end
                end
                idx_next = idx_reg + 3'd1;
                if (idx_reg == SQ_LAST) begin
                    scan_next  = '0;
                    kept_next  = '0;
                    state_next = S_AGE;
                end
            end
            // Compact the stamps still inside the window, one per cycle
            S_AGE: begin
                if (scan_reg < total_reg) begin
                    if (age <= TIME_W'(win_reg)) begin
                        st_we     = 1'b1;
                        kept_next = kept_reg + CNT_W'(1);
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end else begin
                    state_next = S_FIN;
                end
            end
            // Threshold test, store and shake decision
            S_FIN: begin
                prev_x_next     = ax_reg;
                prev_y_next     = ay_reg;
                prev_z_next     = az_reg;
                res_shake_next  = 1'b0;
                res_masked_next = 1'b0;
                if (crossing) begin
                    if (kept_reg < CNT_W'(SPIKES_NEEDED)) begin
                        st_we     = 1'b1;
                        st_wdata  = now_reg;
                        cnt_after = kept_reg + CNT_W'(1);
                    end
                end
                total_next    = cnt_after;
                res_held_next = cnt_after;
                if (crossing && (cnt_after >= CNT_W'(SPIKES_NEEDED))) begin
                    res_shake_next = 1'b1;
                    total_next     = '0;
                    res_held_next  = '0;
                    deadline_next  = now_reg + TIME_W'(cool_reg);
                end
                state_next = S_OUT;
            end
            // Hand the result to the output register once it is free
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_masked_reg, HELD_W'(res_held_reg),
                                     res_shake_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, control and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            first_reg     <= 1'b1;
            total_reg     <= '0;
            deadline_reg  <= '0;
            thr_reg       <= THRESHOLD_RST;
            win_reg       <= WINDOW_RST;
            cool_reg      <= COOLDOWN_RST;
            idx_reg       <= SQ_X;
            prod_live_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            prev_z_reg    <= prev_z_next;
            first_reg     <= first_next;
            total_reg     <= total_next;
            deadline_reg  <= deadline_next;
            thr_reg       <= thr_next;
            win_reg       <= win_next;
            cool_reg      <= cool_next;
            idx_reg       <= idx_next;
            prod_live_reg <= prod_live_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        cmd_reg        <= cmd_next;
        now_reg        <= now_next;
        valid_reg      <= valid_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        az_reg         <= az_next;
        mlen_reg       <= mlen_next;
        prod_reg       <= prod_next;
        prod_tag_reg   <= prod_tag_next;
        acc_reg        <= acc_next;
        thr2_reg       <= thr2_next;
        scan_reg       <= scan_next;
        kept_reg       <= kept_next;
        res_shake_reg  <= res_shake_next;
        res_held_reg   <= res_held_next;
        res_masked_reg <= res_masked_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // Stamp store write port
    always_ff @(posedge aclk) begin
        if (st_we) begin
            stamps_mem[st_waddr] <= st_wdata;
        end
    end

endmodule

// ===== design/asd_checker.sv =====
module asd_checker
    import asd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The block works on one word at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in work");

    // A shake clears the spike count
    a_shake_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[3:1] == 3'd0) && !m_tdata[4])
        else $error("shake reported with spikes held or masked");

    // A masked word carries no spikes
    a_mask_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> (m_tdata[3:1] == 3'd0))
        else $error("masked word reported with spikes held");

endmodule

bind accel_shake_detector asd_checker u_asd_checker (.*);

// ===== sim/tb_accel_shake_detector.sv =====
`timescale 1ns / 100ps

import asd_pkg::*;

typedef struct packed {
    logic              shake;
    logic [HELD_W-1:0] held;
    logic              masked;
} shake_report_t;

// Mirrors the detector state and holds the reports still owed by the block
class shake_tracker;
    logic [REG_W-1:0]          threshold;
    logic [REG_W-1:0]          window;
    logic [REG_W-1:0]          cooldown;
    logic signed [ACCEL_W-1:0] last_x, last_y, last_z;
    bit                        first_pending;
    logic [TIME_W-1:0]         stamps [SPIKES_NEEDED];
    int                        held;
    logic [TIME_W-1:0]         deadline;
    shake_report_t             expected_reports [$];
    int                        failures;

    function new();
        threshold     = THRESHOLD_RST;
        window        = WINDOW_RST;
        cooldown      = COOLDOWN_RST;
        last_x        = '0;
        last_y        = '0;
        last_z        = '0;
        first_pending = 1'b1;
        held          = 0;
        deadline      = '0;
        failures      = 0;
        foreach (stamps[i]) stamps[i] = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
        case (idx)
            CFG_SPIKE_THRESHOLD: threshold = value;
            CFG_WINDOW_MS:       window    = value;
            CFG_COOLDOWN_MS:     cooldown  = value;
            default: ;
        endcase
    endfunction

    function longint axis_energy(logic signed [ACCEL_W-1:0] a, logic signed [ACCEL_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    function int pending();
        return expected_reports.size();
    endfunction

    // Work out the report for one accepted input word
    function void note_word(logic cmd, logic [IN_DATA_W-1:0] w);
        logic [TIME_W-1:0]         now, mlen, age;
        logic signed [ACCEL_W-1:0] ax, ay, az;
        longint                    change, limit;
        int                        kept;
        shake_report_t             r;
        now  = w[31:0];
        ax   = w[48:33];
        ay   = w[64:49];
        az   = w[80:65];
        mlen = w[112:81];
        r    = '0;
        if (cmd == CMD_MASK) begin
            deadline = now + mlen;
        end else if (now < deadline) begin
            // suppressed: drop spikes, re-arm first sample
            held          = 0;
            first_pending = 1'b1;
            r.masked      = 1'b1;
        end else if (w[32]) begin
            if (first_pending) begin
                first_pending = 1'b0;
            end else begin
                change = axis_energy(ax, last_x) + axis_energy(ay, last_y) +
                         axis_energy(az, last_z);
                limit  = longint'(threshold) * longint'(threshold);
                // age out old stamps, keeping order
                kept = 0;
                for (int i = 0; i < held; i++) begin
                    age = now - stamps[i];
                    if (age <= window) begin
                        stamps[kept] = stamps[i];
                        kept++;
                    end
                end
                held = kept;
                if (change > limit) begin
                    if (held < SPIKES_NEEDED) begin
                        stamps[held] = now;
                        held++;
                    end
                    if (held >= SPIKES_NEEDED) begin
                        r.shake  = 1'b1;
                        held     = 0;
                        deadline = now + cooldown;
                    end
                end
            end
            last_x = ax;
            last_y = ay;
            last_z = az;
        end
        r.held = HELD_W'(held);
        expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
            failures++;
        end
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] word);
        shake_report_t e;
        if (expected_reports.size() == 0) begin
            $display("%0t: result word %h arrived with nothing expected", $time, word);
            failures++;
            return;
        end
        e = expected_reports.pop_front();
        compare_field("shake", e.shake, word[0]);
        compare_field("spikes_held", e.held, word[3:1]);
        compare_field("masked", e.masked, word[4]);
    endfunction
endclass

module tb_accel_shake_detector;

    localparam logic [CFG_IDX_W-1:0]   CFG_SPARE   = 2'd3;
    localparam logic signed [ACCEL_W-1:0] ACC_MAX  = 16'sh7FFF;
    localparam logic signed [ACCEL_W-1:0] ACC_MIN  = 16'sh8000;
    localparam int                     PHASE_WORDS = 204;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [REG_W-1:0]      cfg_data;

    bit                        gaps_on = 1'b1;
    shake_tracker              tracker = new();
    logic [TIME_W-1:0]         clock_ms;
    logic signed [ACCEL_W-1:0] gx, gy, gz;

    accel_shake_detector dut (.*);

    always #4 aclk = ~aclk;

    // Result side: random back-pressure, check on every accepted word
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= !(gaps_on && $urandom_range(99) < 13);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_report(m_tdata);
    end

    // One input word; valid is left high, the next call or drain() decides
    task automatic send_item(input logic cmd, input logic [TIME_W-1:0] now,
                             input logic valid, input logic signed [ACCEL_W-1:0] x,
                             input logic signed [ACCEL_W-1:0] y,
                             input logic signed [ACCEL_W-1:0] z,
                             input logic [TIME_W-1:0] mlen);
        @(negedge aclk);
        while (gaps_on && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, mlen, z, y, x, valid, now};
        do @(posedge aclk); while (!s_tready);
        tracker.note_word(cmd, s_tdata);
    endtask

    // Unused fields carry random bits
    task automatic send_sample(input logic [TIME_W-1:0] now, input logic valid,
                               input logic signed [ACCEL_W-1:0] x,
                               input logic signed [ACCEL_W-1:0] y,
                               input logic signed [ACCEL_W-1:0] z);
        send_item(CMD_SAMPLE, now, valid, x, y, z, $urandom);
    endtask

    task automatic send_mask(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] len);
        send_item(CMD_MASK, now, 1'($urandom), ACCEL_W'($urandom), ACCEL_W'($urandom),
                  ACCEL_W'($urandom), len);
    endtask

    // Stop sending and wait for every owed report
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_register(idx, value);
    endtask

    task automatic configure(input logic [REG_W-1:0] thr, input logic [REG_W-1:0] win,
                             input logic [REG_W-1:0] cool, input bit spare);
        write_reg(CFG_SPIKE_THRESHOLD, thr);
        write_reg(CFG_WINDOW_MS, win);
        write_reg(CFG_COOLDOWN_MS, cool);
        // out-of-range index must leave everything alone
        if (spare) write_reg(CFG_SPARE, REG_W'($urandom));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a plausible time-ordered sample stream, some masks and noise
    task automatic random_words(input int n);
        int unsigned       pick;
        int unsigned       win, cool;
        logic [TIME_W-1:0] mlen;
        for (int k = 0; k < n; k++) begin
            win  = 32'(tracker.window);
            cool = 32'(tracker.cooldown);
            pick = $urandom_range(99);
            if (pick < 3)       clock_ms = $urandom;
            else if (pick < 5)  clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
            else if (pick < 13) clock_ms += $urandom_range(2 * cool + 50);
            else                clock_ms += $urandom_range(win / 3 + 2);

            pick = $urandom_range(99);
            if (pick < 5) begin
                mlen = ($urandom_range(9) < 7) ? $urandom_range(3000) : $urandom;
                send_mask(clock_ms, mlen);
            end else if (pick < 10) begin
                send_item(1'($urandom), $urandom, 1'($urandom), ACCEL_W'($urandom),
                          ACCEL_W'($urandom), ACCEL_W'($urandom), $urandom);
            end else begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    gx = ACCEL_W'($urandom);
                    gy = ACCEL_W'($urandom);
                    gz = ACCEL_W'($urandom);
                end else if (pick < 55) begin
                    gx = $urandom_range(1) ? ACC_MAX : ACC_MIN;
                    gy = $urandom_range(1) ? ACC_MAX : ACC_MIN;
                    gz = $urandom_range(1) ? ACC_MAX : ACC_MIN;
                end else begin
                    // small jitter, no spike at usual thresholds
                    gx = gx + $signed(ACCEL_W'($urandom_range(64) - 32));
                    gy = gy + $signed(ACCEL_W'($urandom_range(64) - 32));
                    gz = gz + $signed(ACCEL_W'($urandom_range(64) - 32));
                end
                send_sample(clock_ms, $urandom_range(99) < 92, gx, gy, gz);
            end
            if (k % 100 == 99) drain();
        end
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SPIKE_THRESHOLD;
        cfg_data  = '0;
        clock_ms  = '0;
        gx        = '0;
        gy        = '0;
        gz        = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings
        send_sample(100, 1'b0, ACC_MAX, 0, 0);            // failed read
        send_sample(110, 1'b1, 0, 0, 0);                  // first sample
        send_sample(120, 1'b1, ACC_MAX, ACC_MIN, ACC_MAX);
        send_sample(130, 1'b1, ACC_MIN, ACC_MAX, ACC_MIN); // largest change
        send_sample(1120, 1'b1, ACC_MIN, ACC_MAX, ACC_MIN); // stamp exactly at window
        send_sample(1121, 1'b1, -27853, ACC_MAX, ACC_MIN); // change equals threshold
        send_sample(1122, 1'b1, -22937, ACC_MAX, ACC_MIN); // one above threshold
        send_sample(1123, 1'b1, ACC_MAX, ACC_MIN, ACC_MAX);
        send_sample(1124, 1'b1, ACC_MIN, ACC_MAX, ACC_MIN); // shake, cooldown starts
        send_sample(1200, 1'b1, 0, 0, 0);                 // masked
        send_sample(1300, 1'b0, 0, 0, 0);                 // masked, read failed
        send_mask(1300, 0);                               // deadline equals now
        send_sample(1300, 1'b1, 100, 200, 300);           // not masked, first sample
        send_mask(32'hFFFF_FF00, 32'h200);                // deadline wraps
        send_sample(32'hFFFF_FF10, 1'b1, ACC_MAX, ACC_MAX, ACC_MAX);
        send_sample(32'h0000_0150, 1'b1, ACC_MIN, ACC_MIN, ACC_MIN); // age across wrap
        send_mask(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h0000_0200, 1'b1, 0, 0, 0);        // masked
        send_mask(0, 0);
        send_sample(5, 1'b1, 0, 0, 0);
        send_sample(6, 1'b1, 0, 0, 0);
        drain();

        // Random phases, each under its own register settings
        clock_ms = 32'd10_000;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: configure(4000, 1000, 300, 1'b1);
                1: configure(0, 0, 0, 1'b0);
                2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                3: configure(20000, 200, 1000, 1'b0);
                4: configure(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), 1'b1);
                5: configure(30000, 3000, 100, 1'b0);
                default: configure(REG_W'($urandom_range(8000)),
                                   REG_W'($urandom_range(2000)),
                                   REG_W'($urandom_range(500)), 1'b1);
            endcase
            gaps_on = (p != 3);
            random_words(PHASE_WORDS);
            drain();
        end
        gaps_on = 1'b1;

        repeat (40) @(posedge aclk);
        if (tracker.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
